[rtl/multi_digit_seven_segment_encoder_core_assert.svh]
// assertion macros for the checker file
`ifndef MULTI_DIGIT_SEVEN_SEGMENT_ENCODER_CORE_ASSERT_SVH
`define MULTI_DIGIT_SEVEN_SEGMENT_ENCODER_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define MDSSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MDSSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mdsse_pkg.sv]
package mdsse_pkg;

    localparam int DIGIT_W      = 4;
    localparam int DISP_W       = 2;
    localparam int SEG_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int NUMBER_W     = 16;
    localparam int IDX_IN_W     = 4;
    // wide enough for the all-nines value of the largest display count
    localparam int VAL_W        = 14;
    localparam int MAX_DISPLAYS = 4;
    localparam int DEF_NUM_DISPLAYS = 4;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

    localparam logic CMD_NUMBER = 1'b0;
    localparam logic CMD_SINGLE = 1'b1;

    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // x / 10 == (x * 52429) >> 19 for every x below 2^16
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                single;
        logic [DISP_W-1:0]   idx;
        logic [VAL_W-1:0]    value;
    } t_token;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // all-nines value for n digits, evaluated at elaboration
    function automatic int max_value(input int n);
        int v;
        v = 0;
        for (int i = 0; i < n; i++) begin
            v = v * 10 + 9;
        end
        return v;
    endfunction

endpackage

[rtl/mdsse_cell.sv]
module mdsse_cell
    import mdsse_pkg::*;
#(
    parameter int NUM_DISPLAYS = DEF_NUM_DISPLAYS,
    parameter int CELL_IDX     = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  t_token                          i_tok,
    input  logic [NUM_DISPLAYS*DIGIT_W-1:0] i_digits,
    output logic                            o_valid,
    output t_token                          o_tok,
    output logic [NUM_DISPLAYS*DIGIT_W-1:0] o_digits
);

    localparam int ProdW = VAL_W + 16;

    logic                            r_valid;
    t_token                          r_tok;
    logic [NUM_DISPLAYS*DIGIT_W-1:0] r_digits;

    logic [ProdW-1:0]                prod;
    logic [VAL_W-1:0]                quot;
    logic [VAL_W-1:0]                quot_x10;
    logic [VAL_W-1:0]                rem;
    t_token                          n_tok;
    logic [NUM_DISPLAYS*DIGIT_W-1:0] n_digits;

    // one divide by ten per cell: digit drops out here, quotient moves on
    always_comb begin
        prod     = ProdW'(i_tok.value) * ProdW'(RECIP_10);
        quot     = VAL_W'(prod >> RECIP_SHIFT);
        quot_x10 = (quot << 3) + (quot << 1);
        rem      = i_tok.value - quot_x10;
        n_tok        = i_tok;
        n_tok.value  = quot;
        n_digits     = i_digits;
        n_digits[CELL_IDX*DIGIT_W +: DIGIT_W] = rem[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok    <= n_tok;
            r_digits <= n_digits;
        end
    end

    assign o_valid  = r_valid;
    assign o_tok    = r_tok;
    assign o_digits = r_digits;

endmodule

[rtl/mdsse_emit.sv]
module mdsse_emit
    import mdsse_pkg::*;
#(
    parameter int NUM_DISPLAYS = DEF_NUM_DISPLAYS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  t_token                          i_tok,
    input  logic [NUM_DISPLAYS*DIGIT_W-1:0] i_digits,
    input  logic [MAX_DISPLAYS-1:0]         i_polarity,
    output logic                            o_load,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [DISP_W-1:0]               o_target,
    output logic [SEG_W-1:0]                o_pattern,
    output logic [STATUS_W-1:0]             o_status,
    output logic                            o_last
);

    localparam logic [DISP_W-1:0] LastCnt = DISP_W'(NUM_DISPLAYS - 1);

    logic                            r_busy;
    t_token                          r_tok;
    logic [NUM_DISPLAYS*DIGIT_W-1:0] r_digits;
    logic [DISP_W-1:0]               r_cnt;

    logic                            is_err;
    logic                            last;
    logic                            xfer;
    logic                            done;
    logic [DISP_W-1:0]               disp;
    logic [SEG_W-1:0]                pat;

    always_comb begin
        is_err = (r_tok.status != ST_OK);
        last   = is_err || r_tok.single || (r_cnt == LastCnt);
        xfer   = r_busy && i_tready;
        done   = xfer && last;
        o_load = i_valid && (!r_busy || done);
        disp   = r_tok.single ? r_tok.idx : r_cnt;
        pat    = seg_of(r_digits[DIGIT_W-1:0]) ^ {SEG_W{i_polarity[disp]}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_load) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    // digits shift down so the current one always sits in the low nibble
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_tok    <= i_tok;
            r_digits <= i_digits;
            r_cnt    <= '0;
        end else if (xfer) begin
            r_digits <= r_digits >> DIGIT_W;
            r_cnt    <= r_cnt + 1'b1;
        end
    end

    assign o_tvalid  = r_busy;
    assign o_target  = is_err ? '0 : disp;
    assign o_pattern = is_err ? '0 : pat;
    assign o_status  = r_tok.status;
    assign o_last    = last;

endmodule

[rtl/multi_digit_seven_segment_encoder_core.sv]
// Seven-segment encoder for up to four displays.
// Input stream: s_axis_tuser is the command (0 number, 1 single digit);
// s_axis_tdata carries display index, digit and a 16-bit number.
// A number command gives one transfer per display, display 0 first, the
// least significant decimal digit there; a single-digit command gives one
// transfer. A rejected command gives one transfer with the status in
// m_axis_tuser, tdata zero. m_axis_tlast marks the final transfer of a command.
// i_cfg_we writes the common-anode mask, one bit per display.
// The first result of a command is registered in each divide-by-ten cell of
// the chain in turn and then in the output stage.
// The output stage sets the pace: a number command holds the output for one
// transfer per display, other commands one transfer. The chain moves only
// while its last cell is empty or hands its command to the output stage.
// Reset empties the chain and the output stage and clears the mask.
// When m_axis_tready is low the output holds; once the last cell holds a
// command the whole chain stalls and s_axis_tready drops until the output stage takes it.
module multi_digit_seven_segment_encoder_core
    import mdsse_pkg::*;
#(
    parameter int NUM_DISPLAYS = DEF_NUM_DISPLAYS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // display_index[3:0], digit[7:4], number[23:8]
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // cmd[0]
    input  logic [0:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // target_display[1:0], segment_pattern[9:2], zero[15:10]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]     m_axis_tuser,
    output logic                    m_axis_tlast,
    input  logic                    i_cfg_we,
    input  logic [MAX_DISPLAYS-1:0] i_cfg_wdata
);

    localparam logic [NUMBER_W-1:0] MaxNumber = NUMBER_W'(max_value(NUM_DISPLAYS));
    localparam int DigW = NUM_DISPLAYS * DIGIT_W;

    logic [MAX_DISPLAYS-1:0] r_polarity;

    logic [IDX_IN_W-1:0]     in_idx;
    logic [DIGIT_W-1:0]      in_digit;
    logic [NUMBER_W-1:0]     in_number;
    t_token                  in_tok;

    logic                    chain_en;
    logic                    load;
    logic                    chain_valid [NUM_DISPLAYS+1];
    t_token                  chain_tok   [NUM_DISPLAYS+1];
    logic [DigW-1:0]         chain_dig   [NUM_DISPLAYS+1];

    logic [DISP_W-1:0]       out_target;
    logic [SEG_W-1:0]        out_pattern;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= '0;
        end else if (i_cfg_we) begin
            r_polarity <= i_cfg_wdata;
        end
    end

    // checks and token setup; a single digit rides through the chain as a value
    always_comb begin
        in_idx    = s_axis_tdata[3:0];
        in_digit  = s_axis_tdata[7:4];
        in_number = s_axis_tdata[23:8];
        in_tok.single = (s_axis_tuser[0] == CMD_SINGLE);
        in_tok.idx    = in_idx[DISP_W-1:0];
        if (s_axis_tuser[0] == CMD_NUMBER) begin
            in_tok.status = (in_number > MaxNumber) ? ST_TOO_LARGE : ST_OK;
            in_tok.value  = in_number[VAL_W-1:0];
        end else begin
            if (in_idx >= IDX_IN_W'(NUM_DISPLAYS)) begin
                in_tok.status = ST_BAD_INDEX;
            end else if (in_digit > MAX_DIGIT) begin
                in_tok.status = ST_BAD_DIGIT;
            end else begin
                in_tok.status = ST_OK;
            end
            in_tok.value = VAL_W'(in_digit);
        end
    end

    assign chain_en       = !chain_valid[NUM_DISPLAYS] || load;
    assign s_axis_tready  = chain_en;
    assign chain_valid[0] = s_axis_tvalid;
    assign chain_tok[0]   = in_tok;
    assign chain_dig[0]   = '0;

    for (genvar g = 0; g < NUM_DISPLAYS; g++) begin : g_cell
        mdsse_cell #(
            .NUM_DISPLAYS (NUM_DISPLAYS),
            .CELL_IDX     (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (chain_en),
            .i_valid  (chain_valid[g]),
            .i_tok    (chain_tok[g]),
            .i_digits (chain_dig[g]),
            .o_valid  (chain_valid[g+1]),
            .o_tok    (chain_tok[g+1]),
            .o_digits (chain_dig[g+1])
        );
    end

    mdsse_emit #(
        .NUM_DISPLAYS (NUM_DISPLAYS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (chain_valid[NUM_DISPLAYS]),
        .i_tok      (chain_tok[NUM_DISPLAYS]),
        .i_digits   (chain_dig[NUM_DISPLAYS]),
        .i_polarity (r_polarity),
        .o_load     (load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_target   (out_target),
        .o_pattern  (out_pattern),
        .o_status   (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_DATA_W - DISP_W - SEG_W)'(0), out_pattern, out_target};

endmodule

[rtl/mdsse_checker.sv]
`include "multi_digit_seven_segment_encoder_core_assert.svh"

module mdsse_checker
    import mdsse_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [STATUS_W-1:0]     m_axis_tuser,
    input logic                    m_axis_tlast
);

    // a result waiting on the receiver stays offered
    `MDSSE_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")

    // rejected commands give one blank result
    `MDSSE_ASSERT(a_err_single, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast && (m_axis_tdata == '0), "error result not a blank final transfer")

    // only a good number command gives more than one result
    `MDSSE_ASSERT(a_multi_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_OK, "non-final result carries an error status")

    // displays of a number command come out in rising order without a gap
    `MDSSE_ASSERT(a_disp_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tdata[1:0] == DISP_W'($past(m_axis_tdata[1:0]) + 2'd1)), "display order broken inside a number command")

    // a reset leaves the output offering nothing and the input ready
    `MDSSE_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "output busy right after reset")

endmodule

bind multi_digit_seven_segment_encoder_core mdsse_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import mdsse_pkg::*;

    localparam int NUM_DISPLAYS = 4;

    typedef struct packed {
        logic [DISP_W-1:0]   disp;
        logic [SEG_W-1:0]    pattern;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_seg_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]              s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    i_cfg_we = 1'b0;
    logic [MAX_DISPLAYS-1:0] i_cfg_wdata = '0;

    t_seg_result             pending_segments[$];
    logic [MAX_DISPLAYS-1:0] anode_mask = '0;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    int                      rx_hold_left = 0;
    int                      mismatches = 0;
    int                      commands_sent = 0;
    int                      transfers_seen = 0;

    multi_digit_seven_segment_encoder_core #(
        .NUM_DISPLAYS(NUM_DISPLAYS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // segments a..g in bits 0..6 for one decimal digit, with the anode mask applied
    function automatic logic [SEG_W-1:0] digit_segments(input int unsigned disp,
            input int unsigned d);
        logic [SEG_W-1:0] p;
        case (d)
            0:       p = 8'b0011_1111;
            1:       p = 8'b0000_0110;
            2:       p = 8'b0101_1011;
            3:       p = 8'b0100_1111;
            4:       p = 8'b0110_0110;
            5:       p = 8'b0110_1101;
            6:       p = 8'b0111_1101;
            7:       p = 8'b0000_0111;
            8:       p = 8'b0111_1111;
            default: p = 8'b0110_1111;
        endcase
        if (anode_mask[disp])
            p = ~p;
        return p;
    endfunction

    function automatic void predict_segments(input logic cmd, input logic [3:0] idx,
            input logic [3:0] dig, input logic [15:0] num);
        t_seg_result r;
        int unsigned all_nines;
        int unsigned val;
        all_nines = 0;
        for (int i = 0; i < NUM_DISPLAYS; i++)
            all_nines = all_nines * 10 + 9;
        r = '0;
        r.last = 1'b1;
        if (cmd == CMD_NUMBER) begin
            if (num > all_nines) begin
                r.status = ST_TOO_LARGE;
                pending_segments.push_back(r);
            end else begin
                val = 32'(num);
                for (int i = 0; i < NUM_DISPLAYS; i++) begin
                    r.disp    = DISP_W'(i);
                    r.pattern = digit_segments(i, val % 10);
                    r.status  = ST_OK;
                    r.last    = (i == NUM_DISPLAYS - 1);
                    pending_segments.push_back(r);
                    val = val / 10;
                end
            end
        end else if (idx >= NUM_DISPLAYS) begin
            r.status = ST_BAD_INDEX;
            pending_segments.push_back(r);
        end else if (dig > MAX_DIGIT) begin
            r.status = ST_BAD_DIGIT;
            pending_segments.push_back(r);
        end else begin
            r.disp    = idx[DISP_W-1:0];
            r.pattern = digit_segments(32'(idx), 32'(dig));
            r.status  = ST_OK;
            pending_segments.push_back(r);
        end
    endfunction

    // output side readiness: long hold first, otherwise random stalls
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_seg_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            transfers_seen++;
            if (pending_segments.size() == 0) begin
                $display("%0t: transfer with nothing expected: tdata %h tuser %0d tlast %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_segments.pop_front();
                if (m_axis_tdata[1:0] !== want.disp) begin
                    $display("%0t: display expected %0d actual %0d",
                             $time, want.disp, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[9:2] !== want.pattern) begin
                    $display("%0t: segments expected %h actual %h",
                             $time, want.pattern, m_axis_tdata[9:2]);
                    mismatches++;
                end
                if (m_axis_tdata[15:10] !== '0) begin
                    $display("%0t: tdata padding expected 0 actual %h",
                             $time, m_axis_tdata[15:10]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: tlast expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_command(input logic cmd, input logic [3:0] idx,
            input logic [3:0] dig, input logic [15:0] num);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {num, dig, idx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_segments(cmd, idx, dig, num);
        commands_sent++;
    endtask

    task automatic send_random_command();
        logic [3:0]  idx;
        logic [3:0]  dig;
        logic [15:0] num;
        int unsigned pick;
        idx  = 4'($urandom_range(15));
        dig  = 4'($urandom_range(15));
        num  = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 50) begin
            if (pick < 6)
                num = 16'($urandom_range(65535, 10000));
            else if (pick < 9)
                num = ($urandom_range(1) != 0) ? 16'd9999 : 16'd0;
            else if (pick < 15)
                num = 16'($urandom_range(9));
            else
                num = 16'($urandom_range(9999));
            send_command(CMD_NUMBER, idx, dig, num);
        end else begin
            if (pick < 85)
                idx = 4'($urandom_range(NUM_DISPLAYS - 1));
            if (pick < 90)
                dig = 4'($urandom_range(9));
            send_command(CMD_SINGLE, idx, dig, num);
        end
    endtask

    // stop offering and wait out every pending result plus the chain depth
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge i_clk);
        repeat (NUM_DISPLAYS + 4) @(posedge i_clk);
    endtask

    task automatic load_polarity(input logic [MAX_DISPLAYS-1:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        anode_mask = m;
    endtask

    task automatic test_directed();
        tx_idle_pct = 35;
        rx_idle_pct = 48;
        load_polarity(4'h0);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd0);
        send_command(CMD_NUMBER, 4'hF, 4'hF, 16'd9999);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd1234);
        send_command(CMD_NUMBER, 4'h5, 4'hA, 16'd5678);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd9090);
        // just past the all-nines limit, and the largest value
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd10000);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'hFFFF);
        send_command(CMD_SINGLE, 4'd0, 4'd0, 16'hFFFF);
        send_command(CMD_SINGLE, 4'd1, 4'd9, 16'h0000);
        send_command(CMD_SINGLE, 4'd2, 4'd5, 16'h1234);
        send_command(CMD_SINGLE, 4'd3, 4'd7, 16'h0000);
        send_command(CMD_SINGLE, 4'd4, 4'd3, 16'h0000);
        // bad index wins over bad digit
        send_command(CMD_SINGLE, 4'd15, 4'd15, 16'h0000);
        send_command(CMD_SINGLE, 4'd2, 4'd10, 16'h0000);
        send_command(CMD_SINGLE, 4'd3, 4'd15, 16'h0000);
        drain_results();
        load_polarity(4'hF);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd8080);
        send_command(CMD_SINGLE, 4'd0, 4'd8, 16'h0000);
        send_command(CMD_SINGLE, 4'd3, 4'd1, 16'h0000);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd12345);
        drain_results();
        load_polarity(4'h5);
        send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd4321);
        send_command(CMD_SINGLE, 4'd1, 4'd2, 16'h0000);
        send_command(CMD_SINGLE, 4'd2, 4'd6, 16'h0000);
        drain_results();
    endtask

    task automatic test_random();
        tx_idle_pct = 35;
        rx_idle_pct = 48;
        load_polarity(4'hA);
        repeat (40) send_random_command();
        drain_results();
        tx_idle_pct = 48;
        rx_idle_pct = 35;
        load_polarity(MAX_DISPLAYS'($urandom_range(15)));
        repeat (40) send_random_command();
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_polarity(MAX_DISPLAYS'($urandom_range(15)));
        repeat (40) send_random_command();
        drain_results();
    endtask

    // output held off long enough that the chain fills and input stalls
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_polarity(MAX_DISPLAYS'($urandom_range(15)));
        rx_hold_left = 200;
        repeat (16) send_random_command();
        drain_results();
        rx_idle_pct = 48;
        repeat (6) send_random_command();
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        $display("summary: %0d commands, %0d segment transfers, %0d mismatches",
                 commands_sent, transfers_seen, mismatches);
        $display("covered number and single-digit commands, all status codes, several masks, stalls");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
